// ===== src/pfvc_pkg.sv =====
// Package for the PCM format and volume converter.
// Holds the configuration and queue entry types, register indexes and the constants
// of the scaling arithmetic. No dependencies.
package pfvc_pkg;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam int          VOL_W       = 7;
	localparam logic [6:0]  VOL_MAX     = 7'd100;
	localparam int          MAG_W       = 23;
	localparam int          RECIP_SHIFT = 24;
	localparam logic [17:0] RECIP_MUL   = 18'd167772;
	localparam int          QUO_W       = 17;
	localparam logic [7:0]  DIVISOR     = 8'd100;

	typedef enum logic [1:0] {
		REG_SIXTEEN_BIT = 2'd0,
		REG_STEREO      = 2'd1,
		REG_VOLUME      = 2'd2,
		REG_PACKAGE     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic        sixteen_bit_mode;
		logic        stereo_mode;
		logic [6:0]  volume_percent;
		logic [15:0] package_bytes;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               package_end;
		logic               stereo;
	} entry_t;

endpackage

// ===== src/pfvc_ifs.sv =====
// Handshake channels of the PCM format and volume converter.
// Source item channel and result channel, each with valid, ready and payload.
// No dependencies.
interface pfvc_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [15:0] sample_raw;

	modport source (output valid, output op, output sample_raw, input ready);
	modport sink (input valid, input op, input sample_raw, output ready);
endinterface

interface pfvc_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] out_sample;
	logic               right_channel;
	logic               run_last;
	logic               package_end;

	modport source (output valid, output out_sample, output right_channel,
		output run_last, output package_end, input ready);
	modport sink (input valid, input out_sample, input right_channel,
		input run_last, input package_end, output ready);
endinterface

// ===== src/pfvc_front.sv =====
// Front end: accepts source transactions, widens samples and tracks package position.
// Depends on pfvc_pkg and pfvc_in_if.
module pfvc_front (
	input  logic              clk,
	input  logic              arst_n,
	pfvc_in_if.sink           samples,
	input  pfvc_pkg::cfg_t    cfg,
	input  logic              queue_full,
	output logic              push,
	output pfvc_pkg::entry_t  push_entry
);
	import pfvc_pkg::*;

	logic [15:0] pos_q;
	logic [15:0] count;
	logic [16:0] pos_inc;
	logic        pend;
	logic [7:0]  sample_byte;
	logic signed [15:0] widened;

	assign samples.ready = !queue_full;
	assign push          = samples.valid && !queue_full;

	always_comb begin
		count = cfg.sixteen_bit_mode ? {1'b0, cfg.package_bytes[15:1]} : cfg.package_bytes;
		if (count == 16'd0) begin
			count = 16'd1;
		end
		pos_inc = {1'b0, pos_q} + 17'd1;
		pend    = pos_inc >= {1'b0, count};
	end

	always_comb begin
		sample_byte = samples.sample_raw[7:0];
		if (samples.op) begin
			widened = '0;
		end else if (cfg.sixteen_bit_mode) begin
			widened = samples.sample_raw;
		end else begin
			widened = {~sample_byte[7], sample_byte[6:0], sample_byte};
		end
		push_entry.sample      = widened;
		push_entry.package_end = pend;
		push_entry.stereo      = cfg.stereo_mode;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			pos_q <= pend ? 16'd0 : pos_inc[15:0];
		end
	end

endmodule

// ===== src/pfvc_fifo.sv =====
// Short queue between the front end and the arithmetic back end.
// Depends on pfvc_pkg.
module pfvc_fifo #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pfvc_pkg::entry_t  push_entry,
	input  logic              pop,
	output logic              full,
	output logic              head_valid,
	output pfvc_pkg::entry_t  head_entry
);
	import pfvc_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t        mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full       = cnt_q == CW'(DEPTH);
	assign head_valid = cnt_q != '0;
	assign head_entry = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/pfvc_back.sv =====
// Back end: volume scaling with division by 100 through a reciprocal multiply,
// then the output register that sends one or two copies. Depends on pfvc_pkg and pfvc_out_if.
module pfvc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  pfvc_pkg::cfg_t    cfg,
	input  logic              head_valid,
	input  pfvc_pkg::entry_t  head_entry,
	output logic              pop,
	pfvc_out_if.source        results
);
	import pfvc_pkg::*;

	logic [VOL_W-1:0] vol;
	logic [15:0]      abs_sample;
	logic             advance;
	logic             last_copy;

	logic             valid_s1;
	logic [MAG_W-1:0] mag_s1;
	logic             neg_s1;
	logic             pend_s1;
	logic             stereo_s1;

	logic             valid_s2;
	logic [MAG_W-1:0] mag_s2;
	logic [QUO_W-1:0] quo_s2;
	logic             neg_s2;
	logic             pend_s2;
	logic             stereo_s2;

	logic [MAG_W+17:0]  recip_prod;
	logic [MAG_W:0]     rem;
	logic [QUO_W-1:0]   quo_fix;
	logic signed [15:0] scaled;

	logic               valid_q;
	logic signed [15:0] sample_q;
	logic               pend_q;
	logic               stereo_q;
	logic               right_q;

	assign vol        = (cfg.volume_percent > VOL_MAX) ? VOL_MAX : cfg.volume_percent;
	assign abs_sample = head_entry.sample[15] ? 16'(-head_entry.sample) : head_entry.sample;
	assign last_copy  = stereo_q || right_q;
	assign advance    = !valid_q || (results.ready && last_copy);
	assign pop        = advance && head_valid;

	assign recip_prod = (MAG_W + 18)'(mag_s1) * (MAG_W + 18)'(RECIP_MUL);

	always_comb begin
		rem     = (MAG_W + 1)'(mag_s2) - (MAG_W + 1)'(quo_s2 * (QUO_W + 7)'(DIVISOR));
		quo_fix = (rem >= (MAG_W + 1)'(DIVISOR)) ? quo_s2 + 1'b1 : quo_s2;
		scaled  = neg_s2 ? 16'(-quo_fix) : quo_fix[15:0];
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mag_s1    <= MAG_W'(abs_sample) * MAG_W'(vol);
			neg_s1    <= head_entry.sample[15];
			pend_s1   <= head_entry.package_end;
			stereo_s1 <= head_entry.stereo;
			mag_s2    <= mag_s1;
			quo_s2    <= QUO_W'(recip_prod >> RECIP_SHIFT);
			neg_s2    <= neg_s1;
			pend_s2   <= pend_s1;
			stereo_s2 <= stereo_s1;
			sample_q  <= scaled;
			pend_q    <= pend_s2;
			stereo_q  <= stereo_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
			right_q  <= 1'b0;
		end else if (advance) begin
			valid_s1 <= head_valid;
			valid_s2 <= valid_s1;
			valid_q  <= valid_s2;
			right_q  <= 1'b0;
		end else if (results.ready) begin
			right_q <= 1'b1;
		end
	end

	assign results.valid         = valid_q;
	assign results.out_sample    = sample_q;
	assign results.right_channel = right_q;
	assign results.run_last      = last_copy;
	assign results.package_end   = pend_q && last_copy;

endmodule

// ===== src/pcm_format_volume_converter.sv =====
// PCM format and volume converter, top level.
// Source samples enter on the samples channel as transactions carrying op and sample_raw.
// Each is widened to signed 16 bits, scaled by volume_percent/100 with truncation
// toward zero, and leaves on the results channel as signed 16-bit samples.
// In mono mode every transaction gives a left and then a right result; in stereo
// mode it gives one. A pad transaction gives a zero element and advances the package
// position; package_end marks the last result of the element that fills the package.
// An accepted input passes the queue, stages s1 and s2 and the output register.
// Throughput is one input per cycle in stereo mode while results are not stalled; in
// mono mode the single output register sends both copies before it takes the next input.
// A four-entry queue lets the input side keep accepting while results stall; when the
// receiver holds ready low, the result and the pipeline hold and the queue fills, after
// which samples.ready falls. Reset clears the position, the queue and all valid flags
// and loads the registers with 16-bit stereo, volume 100 and a 16-byte package.
// Registers sit on the APB port at byte addresses 0, 4, 8 and 12.
// Depends on pfvc_pkg, pfvc_ifs, pfvc_front, pfvc_fifo and pfvc_back.
module pcm_format_volume_converter #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	pfvc_in_if.sink                       samples,
	pfvc_out_if.source                    results,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pfvc_pkg::PADDR_W-1:0]  paddr,
	input  logic [pfvc_pkg::PDATA_W-1:0]  pwdata,
	output logic [pfvc_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import pfvc_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;
	logic     push;
	entry_t   push_entry;
	logic     queue_full;
	logic     pop;
	logic     head_valid;
	entry_t   head_entry;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sixteen_bit_mode <= 1'b1;
			cfg_q.stereo_mode      <= 1'b1;
			cfg_q.volume_percent   <= VOL_MAX;
			cfg_q.package_bytes    <= 16'd16;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SIXTEEN_BIT: cfg_q.sixteen_bit_mode <= pwdata[0];
				REG_STEREO:      cfg_q.stereo_mode      <= pwdata[0];
				REG_VOLUME:      cfg_q.volume_percent   <= pwdata[6:0];
				REG_PACKAGE:     cfg_q.package_bytes    <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SIXTEEN_BIT: prdata = PDATA_W'(cfg_q.sixteen_bit_mode);
			REG_STEREO:      prdata = PDATA_W'(cfg_q.stereo_mode);
			REG_VOLUME:      prdata = PDATA_W'(cfg_q.volume_percent);
			REG_PACKAGE:     prdata = PDATA_W'(cfg_q.package_bytes);
			default:         prdata = '0;
		endcase
	end

	pfvc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.cfg        (cfg_q),
		.queue_full (queue_full),
		.push       (push),
		.push_entry (push_entry)
	);

	pfvc_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	pfvc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.results    (results)
	);

endmodule

// ===== tb/tb_pcm_format_volume_converter.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the PCM format and volume converter.
// Drives sample transactions and APB register writes, predicts every result transaction
// and compares field by field. Depends on pfvc_pkg, pfvc_ifs and the converter RTL.
module tb_pcm_format_volume_converter;
	import pfvc_pkg::*;

	localparam logic OP_SAMPLE     = 1'b0;
	localparam logic OP_PAD        = 1'b1;
	localparam int   PCT_FULL      = 100;
	localparam int   U8_SCALE      = 257;
	localparam int   U8_OFFSET     = 32768;
	localparam int   SETTLE_CYCLES = 8;
	localparam int   RANDOM_ITEMS  = 1050;
	localparam int   PRINT_CAP     = 40;

	typedef struct packed {
		logic        op;
		logic [15:0] raw;
	} pcm_item_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               right;
		logic               last;
		logic               pend;
	} pcm_out_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	pfvc_in_if  samples_if ();
	pfvc_out_if results_if ();

	pcm_format_volume_converter u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.results (results_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	cfg_t        cfg;
	logic [15:0] elem_pos;
	pcm_item_t   src_queue[$];
	pcm_out_t    expected_pcm[$];
	pcm_item_t   in_flight;
	logic        drv_busy = 1'b0;
	logic        res_fired = 1'b0;
	logic        idle_on = 1'b1;
	int          gap_left = 0;
	int          stall_left = 0;
	int          mismatches = 0;
	int          items_taken = 0;
	int          results_seen = 0;
	int          pkg_ends = 0;
	int          settings_used = 0;

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic predict_element(input pcm_item_t it);
		int                 wide;
		int                 gain;
		int                 count;
		logic signed [15:0] value;
		logic               wrap;
		if (it.op == OP_PAD) begin
			value = '0;
		end else begin
			if (cfg.sixteen_bit_mode)
				wide = $signed(it.raw);
			else
				wide = int'(it.raw[7:0]) * U8_SCALE - U8_OFFSET;
			gain = (int'(cfg.volume_percent) > PCT_FULL) ? PCT_FULL : int'(cfg.volume_percent);
			value = 16'(gain * wide / PCT_FULL);
		end
		count = cfg.sixteen_bit_mode ? int'(cfg.package_bytes >> 1) : int'(cfg.package_bytes);
		if (count == 0)
			count = 1;
		wrap = (int'(elem_pos) + 1 >= count);
		elem_pos = wrap ? 16'd0 : elem_pos + 16'd1;
		if (cfg.stereo_mode) begin
			expected_pcm.push_back({value, 1'b0, 1'b1, wrap});
		end else begin
			expected_pcm.push_back({value, 1'b0, 1'b0, 1'b0});
			expected_pcm.push_back({value, 1'b1, 1'b1, wrap});
		end
	endtask

	always @(posedge clk) begin
		pcm_out_t want;
		if (arst_n) begin
			if (results_if.valid && results_if.ready) begin
				res_fired = 1'b1;
				results_seen++;
				if (expected_pcm.size() == 0) begin
					report_mismatch("unexpected result transaction", results_if.out_sample, 0);
				end else begin
					want = expected_pcm.pop_front();
					if (results_if.out_sample !== want.sample)
						report_mismatch("out_sample", results_if.out_sample, want.sample);
					if (results_if.right_channel !== want.right)
						report_mismatch("right_channel", results_if.right_channel, want.right);
					if (results_if.run_last !== want.last)
						report_mismatch("run_last", results_if.run_last, want.last);
					if (results_if.package_end !== want.pend)
						report_mismatch("package_end", results_if.package_end, want.pend);
					if (want.pend)
						pkg_ends++;
				end
			end
			if (samples_if.valid && samples_if.ready) begin
				predict_element(in_flight);
				items_taken++;
				drv_busy = 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!drv_busy) begin
			if (gap_left > 0) begin
				gap_left--;
				samples_if.valid <= 1'b0;
			end else if (src_queue.size() != 0) begin
				in_flight = src_queue.pop_front();
				samples_if.valid      <= 1'b1;
				samples_if.op         <= in_flight.op;
				samples_if.sample_raw <= in_flight.raw;
				drv_busy = 1'b1;
				gap_left = idle_gap();
			end else begin
				samples_if.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (res_fired)
			stall_left = idle_gap();
		res_fired = 1'b0;
		if (stall_left > 0) begin
			stall_left--;
			results_if.ready <= 1'b0;
		end else begin
			results_if.ready <= 1'b1;
		end
	end

	task automatic queue_item(input logic op, input logic [15:0] raw);
		src_queue.push_back({op, raw});
	endtask

	task automatic wait_idle();
		while (src_queue.size() != 0 || drv_busy || expected_pcm.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [PDATA_W-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_SIXTEEN_BIT: cfg.sixteen_bit_mode = val[0];
			REG_STEREO:      cfg.stereo_mode = val[0];
			REG_VOLUME:      cfg.volume_percent = val[6:0];
			REG_PACKAGE:     cfg.package_bytes = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_config(input logic s16, input logic st, input logic [6:0] vol,
			input logic [15:0] pkg);
		wait_idle();
		apb_write(REG_SIXTEEN_BIT, PDATA_W'(s16));
		apb_write(REG_STEREO, PDATA_W'(st));
		apb_write(REG_VOLUME, PDATA_W'(vol));
		apb_write(REG_PACKAGE, PDATA_W'(pkg));
		settings_used++;
	endtask

	initial begin
		int         phase_len;
		int         left;
		int         r;
		logic [6:0] vol;
		logic [15:0] pkg;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		samples_if.valid = 1'b0;
		samples_if.op = OP_SAMPLE;
		samples_if.sample_raw = '0;
		results_if.ready = 1'b0;
		cfg = '{sixteen_bit_mode: 1'b1, stereo_mode: 1'b1, volume_percent: 7'd100,
			package_bytes: 16'd16};
		elem_pos = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: 16-bit stereo at full volume.
		settings_used++;
		queue_item(OP_SAMPLE, 16'h0000);
		queue_item(OP_SAMPLE, 16'h7FFF);
		queue_item(OP_SAMPLE, 16'h8000);
		queue_item(OP_SAMPLE, 16'hFFFF);
		queue_item(OP_PAD, 16'hA5A5);
		queue_item(OP_SAMPLE, 16'h0001);

		set_config(1'b0, 1'b0, 7'd100, 16'd4);
		queue_item(OP_SAMPLE, 16'h0000);
		queue_item(OP_SAMPLE, 16'h00FF);
		queue_item(OP_SAMPLE, 16'hFF80);
		queue_item(OP_SAMPLE, 16'h0080);
		queue_item(OP_PAD, 16'h0000);

		set_config(1'b1, 1'b1, 7'd0, 16'd1);
		queue_item(OP_SAMPLE, 16'h7FFF);
		queue_item(OP_SAMPLE, 16'h8000);

		set_config(1'b0, 1'b1, 7'd127, 16'd0);
		queue_item(OP_SAMPLE, 16'h00FF);
		queue_item(OP_SAMPLE, 16'h5500);

		// The package is shrunk below the current position between the two halves.
		set_config(1'b1, 1'b1, 7'd50, 16'd24);
		for (int i = 0; i < 9; i++)
			queue_item((i == 4) ? OP_PAD : OP_SAMPLE, 16'($urandom));
		set_config(1'b1, 1'b1, 7'd50, 16'd16);
		queue_item(OP_SAMPLE, 16'hC001);
		queue_item(OP_SAMPLE, 16'h3FFF);

		left = RANDOM_ITEMS;
		while (left > 0) begin
			wait_idle();
			idle_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 4) != 0) begin
				r = $urandom_range(0, 99);
				if (r < 10)
					vol = 7'd0;
				else if (r < 20)
					vol = 7'd100;
				else if (r < 25)
					vol = 7'($urandom_range(101, 127));
				else
					vol = 7'($urandom_range(0, 100));
				r = $urandom_range(0, 99);
				if (r < 80)
					pkg = 16'($urandom_range(0, 48));
				else if (r < 90)
					pkg = 16'hFFFF;
				else
					pkg = 16'($urandom);
				set_config(1'($urandom), 1'($urandom), vol, pkg);
			end
			phase_len = $urandom_range(30, 90);
			if (phase_len > left)
				phase_len = left;
			for (int i = 0; i < phase_len; i++)
				queue_item(($urandom_range(0, 99) < 12) ? OP_PAD : OP_SAMPLE, 16'($urandom));
			left -= phase_len;
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_pcm.size() != 0)
			report_mismatch("results never delivered", 0, expected_pcm.size());
		$display("Covered %0d sample transactions and %0d result transactions under %0d settings.",
			items_taken, results_seen, settings_used);
		$display("Package end flagged %0d times; %0d mismatches recorded.", pkg_ends, mismatches);
		if (mismatches == 0)
			$display("pcm_format_volume_converter regression: pass");
		else
			$display("pcm_format_volume_converter regression: fail");
		$finish;
	end

	initial begin
		#15_000_000;
		$display("Timeout with %0d results outstanding.", expected_pcm.size());
		$display("pcm_format_volume_converter regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
src/pfvc_pkg.sv
src/pfvc_ifs.sv
src/pfvc_front.sv
src/pfvc_fifo.sv
src/pfvc_back.sv
src/pcm_format_volume_converter.sv
tb/tb_pcm_format_volume_converter.sv
